@@ src/bor_pkg.sv @@
// Shared types, constants, and arithmetic helpers for the binaural object renderer.
// Used by the sequencer, the datapath, and the top level; no dependencies.
package bor_pkg;

   localparam int ITD_MAX     = 64;
   localparam int LINE_LEN    = ITD_MAX + 1;
   localparam int PTR_W       = $clog2(LINE_LEN);
   localparam int ITD_DELAY_W = 6;
   localparam int DLY_W       = (PTR_W + 1 > ITD_DELAY_W) ? PTR_W + 1 : ITD_DELAY_W;
   localparam int SMP_W       = 16;
   localparam int ST_W        = 24;
   localparam int OP_W        = 25;
   localparam int PROD_W      = 2 * OP_W;
   localparam int EAR_W       = 29;
   localparam int STEP_W      = 3;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
   localparam logic [STEP_W-1:0] STEP_Y    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ACC  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_TILT = 3'd3;
   localparam logic [STEP_W-1:0] STEP_AIR  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_NEAR = 3'd5;
   localparam logic [STEP_W-1:0] STEP_FAR  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_OUT  = 3'd7;

   localparam logic signed [PROD_W-1:0] HALF15  = PROD_W'(1) << 14;
   localparam logic signed [PROD_W-1:0] HALF12  = PROD_W'(1) << 11;
   localparam logic signed [PROD_W-1:0] ST_MAX  = (PROD_W'(1) << (ST_W - 1)) - 1;
   localparam logic signed [PROD_W-1:0] ST_MIN  = -ST_MAX - 1;
   localparam logic signed [PROD_W-1:0] SMP_MAX = (PROD_W'(1) << (SMP_W - 1)) - 1;
   localparam logic signed [PROD_W-1:0] SMP_MIN = -SMP_MAX - 1;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample_in;
      logic signed [SMP_W-1:0] left_in;
      logic signed [SMP_W-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] left_out;
      logic signed [SMP_W-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        tilt_b0;
      logic signed [15:0] tilt_b1;
      logic signed [15:0] tilt_a1;
      logic [14:0]        air_coeff;
      logic [23:0]        near_scale;
      logic [23:0]        far_scale;
      logic [ITD_DELAY_W-1:0] itd_delay;
      logic               source_right;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_TILT_B0      = 3'd0,
      REG_TILT_B1      = 3'd1,
      REG_TILT_A1      = 3'd2,
      REG_AIR_COEFF    = 3'd3,
      REG_NEAR_SCALE   = 3'd4,
      REG_FAR_SCALE    = 3'd5,
      REG_ITD_DELAY    = 3'd6,
      REG_SOURCE_RIGHT = 3'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      MA_B0   = 3'd0,
      MA_B1   = 3'd1,
      MA_A1   = 3'd2,
      MA_AIR  = 3'd3,
      MA_NEAR = 3'd4,
      MA_FAR  = 3'd5
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_REQ_X = 3'd0,
      MB_X     = 3'd1,
      MB_Y     = 3'd2,
      MB_DIFF  = 3'd3,
      MB_MONO  = 3'd4,
      MB_DLY   = 3'd5
   } mul_b_type;

   typedef enum logic [1:0] {
      JC_NEXT = 2'd0,
      JC_REQ  = 2'd1,
      JC_RSP  = 2'd2
   } jump_type;

   typedef struct packed {
      logic              req_rdy;
      logic              mul_en;
      mul_a_type         a_sel;
      mul_b_type         b_sel;
      logic              ld_in;
      logic              ld_y;
      logic              ld_acc;
      logic              ld_tilt;
      logic              ld_air;
      logic              ld_dly;
      logic              ld_near;
      logic              ld_out;
      jump_type          jc;
      logic [STEP_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic mute;
      logic out_free;
   } seq_status_type;

   function automatic logic signed [PROD_W-1:0] rnd15(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = v + HALF15;
      rnd15 = t >>> 15;
   endfunction

   function automatic logic signed [PROD_W-1:0] rnd12(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = v + HALF12;
      rnd12 = t >>> 12;
   endfunction

   function automatic logic signed [ST_W-1:0] sat_st(input logic signed [PROD_W-1:0] v);
      if (v > ST_MAX) begin
         sat_st = {1'b0, {(ST_W-1){1'b1}}};
      end else if (v < ST_MIN) begin
         sat_st = {1'b1, {(ST_W-1){1'b0}}};
      end else begin
         sat_st = v[ST_W-1:0];
      end
   endfunction

   function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [PROD_W-1:0] v);
      if (v > SMP_MAX) begin
         sat_smp = {1'b0, {(SMP_W-1){1'b1}}};
      end else if (v < SMP_MIN) begin
         sat_smp = {1'b1, {(SMP_W-1){1'b0}}};
      end else begin
         sat_smp = v[SMP_W-1:0];
      end
   endfunction

endpackage

@@ src/bor_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bor_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bor_seq.sv @@
// Microcode sequencer: step counter, control ROM, and conditional jumps.
// Depends on bor_pkg.
module bor_seq
   import bor_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ctl_type        ctl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctl_type           word;
   logic              go;

   function automatic ctl_type rom(input logic [STEP_W-1:0] step);
      ctl_type w;
      w        = '0;
      w.a_sel  = MA_B0;
      w.b_sel  = MB_X;
      w.jc     = JC_NEXT;
      w.target = STEP_WAIT;
      unique case (step)
         STEP_WAIT: begin
            w.req_rdy = 1'b1;
            w.mul_en  = 1'b1;
            w.a_sel   = MA_B0;
            w.b_sel   = MB_REQ_X;
            w.ld_in   = 1'b1;
            w.jc      = JC_REQ;
            w.target  = STEP_OUT;
         end
         STEP_Y: begin
            w.mul_en = 1'b1;
            w.a_sel  = MA_B1;
            w.b_sel  = MB_X;
            w.ld_y   = 1'b1;
         end
         STEP_ACC: begin
            w.mul_en = 1'b1;
            w.a_sel  = MA_A1;
            w.b_sel  = MB_Y;
            w.ld_acc = 1'b1;
         end
         STEP_TILT: begin
            w.mul_en  = 1'b1;
            w.a_sel   = MA_AIR;
            w.b_sel   = MB_DIFF;
            w.ld_tilt = 1'b1;
         end
         STEP_AIR: begin
            w.ld_air = 1'b1;
         end
         STEP_NEAR: begin
            w.mul_en = 1'b1;
            w.a_sel  = MA_NEAR;
            w.b_sel  = MB_MONO;
            w.ld_dly = 1'b1;
         end
         STEP_FAR: begin
            w.mul_en  = 1'b1;
            w.a_sel   = MA_FAR;
            w.b_sel   = MB_DLY;
            w.ld_near = 1'b1;
         end
         STEP_OUT: begin
            w.ld_out = 1'b1;
            w.jc     = JC_RSP;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   always_comb begin
      word = rom(step_ff);
      unique case (word.jc)
         JC_REQ:  go = status.req_valid;
         JC_RSP:  go = status.out_free;
         default: go = 1'b1;
      endcase

      priority if (!go) begin
         step_in = step_ff;
      end else if (word.jc == JC_RSP) begin
         step_in = word.target;
      end else if (word.jc == JC_REQ && status.mute) begin
         step_in = word.target;
      end else begin
         step_in = STEP_W'(step_ff + 1'b1);
      end

      ctl         = word;
      ctl.mul_en  = word.mul_en & go;
      ctl.ld_in   = word.ld_in & go;
      ctl.ld_y    = word.ld_y & go;
      ctl.ld_acc  = word.ld_acc & go;
      ctl.ld_tilt = word.ld_tilt & go;
      ctl.ld_air  = word.ld_air & go;
      ctl.ld_dly  = word.ld_dly & go;
      ctl.ld_near = word.ld_near & go;
      ctl.ld_out  = word.ld_out & go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   a_seq_no_hold: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_WAIT && step_ff != STEP_OUT) |=> step_ff != $past(step_ff))
      else $error("sequencer held in a compute step");

   a_seq_mute_skip: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_WAIT && status.req_valid && status.mute) |=> step_ff == STEP_OUT)
      else $error("muted request did not skip to output step");

endmodule

@@ src/bor_dp.sv @@
// Datapath: shared multiplier, filter and gain registers, delay line, result register.
// Depends on bor_pkg and bor_ram; driven by the control word from bor_seq.
module bor_dp
   import bor_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  ctl_type ctl,
   input  req_type req_data,
   output rsp_type rsp_data
);

   req_type                  in_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [ST_W-1:0]   y_ff;
   logic signed [OP_W-1:0]   diff_ff;
   logic signed [ST_W-1:0]   tilt_ff;
   logic signed [ST_W-1:0]   air_ff;
   logic signed [SMP_W-1:0]  mono_ff;
   logic signed [SMP_W-1:0]  dly_ff;
   logic signed [EAR_W-1:0]  near_ff;
   logic [PTR_W-1:0]         wp_ff;
   logic [LINE_LEN-1:0]      valid_ff;
   logic                     vld_rd_ff;
   logic                     dzero_ff;
   rsp_type                  rsp_ff;

   logic signed [OP_W-1:0]   op_a;
   logic signed [OP_W-1:0]   op_b;
   logic signed [ST_W-1:0]   y_in;
   logic signed [ST_W-1:0]   tilt_in;
   logic signed [ST_W-1:0]   air_in;
   logic signed [SMP_W-1:0]  mono_in;
   logic signed [OP_W-1:0]   diff_in;
   logic signed [SMP_W-1:0]  dly_in;
   logic signed [EAR_W-1:0]  ear_in;
   logic signed [EAR_W-1:0]  left_ear;
   logic signed [EAR_W-1:0]  right_ear;
   rsp_type                  rsp_in;
   logic [DLY_W-1:0]         d_ext;
   logic [DLY_W-1:0]         d_clamp;
   logic [DLY_W-1:0]         rsum;
   logic [PTR_W-1:0]         rd_addr;
   logic [PTR_W-1:0]         wp_next;
   logic                     d_zero;
   logic [SMP_W-1:0]         rd_data;

   always_comb begin
      unique case (ctl.a_sel)
         MA_B0:   op_a = {{(OP_W-15){1'b0}}, cfg.tilt_b0};
         MA_B1:   op_a = OP_W'(cfg.tilt_b1);
         MA_A1:   op_a = OP_W'(cfg.tilt_a1);
         MA_AIR:  op_a = {{(OP_W-15){1'b0}}, cfg.air_coeff};
         MA_NEAR: op_a = {{(OP_W-24){1'b0}}, cfg.near_scale};
         MA_FAR:  op_a = {{(OP_W-24){1'b0}}, cfg.far_scale};
         default: op_a = '0;
      endcase
      unique case (ctl.b_sel)
         MB_REQ_X: op_b = OP_W'(req_data.sample_in);
         MB_X:     op_b = OP_W'(in_ff.sample_in);
         MB_Y:     op_b = OP_W'(y_ff);
         MB_DIFF:  op_b = diff_ff;
         MB_MONO:  op_b = OP_W'(mono_ff);
         MB_DLY:   op_b = OP_W'(dly_ff);
         default:  op_b = '0;
      endcase
   end

   always_comb begin
      y_in    = sat_st(rnd15(prod_ff) + PROD_W'(tilt_ff));
      diff_in = OP_W'(y_ff) - OP_W'(air_ff);
      tilt_in = sat_st(rnd15(acc_ff - prod_ff));
      air_in  = sat_st(PROD_W'(air_ff) + rnd15(prod_ff));
      mono_in = sat_smp(PROD_W'(air_in));
      ear_in  = EAR_W'(rnd12(prod_ff));

      d_ext   = DLY_W'(cfg.itd_delay);
      d_clamp = (d_ext >= DLY_W'(ITD_MAX)) ? DLY_W'(ITD_MAX - 1) : d_ext;
      d_zero  = (d_clamp == '0);
      rsum    = DLY_W'(wp_ff) + DLY_W'(LINE_LEN) - d_clamp;
      rd_addr = (rsum >= DLY_W'(LINE_LEN)) ? PTR_W'(rsum - DLY_W'(LINE_LEN)) : PTR_W'(rsum);
      wp_next = (wp_ff == PTR_W'(LINE_LEN - 1)) ? '0 : PTR_W'(wp_ff + 1'b1);

      priority if (dzero_ff) begin
         dly_in = mono_ff;
      end else if (vld_rd_ff) begin
         dly_in = signed'(rd_data);
      end else begin
         dly_in = '0;
      end

      left_ear  = cfg.source_right ? ear_in : near_ff;
      right_ear = cfg.source_right ? near_ff : ear_in;
      if (cfg.near_scale == '0) begin
         rsp_in.left_out  = in_ff.left_in;
         rsp_in.right_out = in_ff.right_in;
      end else begin
         rsp_in.left_out  = sat_smp(PROD_W'(in_ff.left_in) + PROD_W'(left_ear));
         rsp_in.right_out = sat_smp(PROD_W'(in_ff.right_in) + PROD_W'(right_ear));
      end
   end

   bor_ram #(
      .WIDTH(SMP_W),
      .DEPTH(LINE_LEN)
   ) u_line (
      .clock  (clock),
      .wr_en  (ctl.ld_air),
      .wr_addr(wp_ff),
      .wr_data(mono_in),
      .rd_en  (ctl.ld_air),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_ff  <= '0;
         air_ff   <= '0;
         wp_ff    <= '0;
         valid_ff <= '0;
      end else begin
         if (ctl.ld_tilt) begin
            tilt_ff <= tilt_in;
         end
         if (ctl.ld_air) begin
            air_ff            <= air_in;
            valid_ff[wp_ff]   <= 1'b1;
         end
         if (ctl.ld_dly) begin
            wp_ff <= wp_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctl.ld_in) begin
         in_ff <= req_data;
      end
      if (ctl.ld_y) begin
         y_ff <= y_in;
      end
      if (ctl.ld_acc) begin
         acc_ff  <= prod_ff;
         diff_ff <= diff_in;
      end
      if (ctl.ld_air) begin
         mono_ff   <= mono_in;
         vld_rd_ff <= valid_ff[rd_addr];
         dzero_ff  <= d_zero;
      end
      if (ctl.ld_dly) begin
         dly_ff <= dly_in;
      end
      if (ctl.ld_near) begin
         near_ff <= ear_in;
      end
      if (ctl.ld_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_dp_read_addr: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_air |-> ((rd_addr == wp_ff) == d_zero))
      else $error("delay line read address collides with write address");

   a_dp_wp_range: assert property (@(posedge clock) disable iff (reset)
      DLY_W'(wp_ff) < DLY_W'(LINE_LEN))
      else $error("delay line write pointer out of range");

endmodule

@@ src/binaural_object_renderer.sv @@
// Binaural object renderer top level: APB register file, handshake, sequencer, datapath.
// Each accepted request runs the eight-step microcode program sharing one 25x25 multiplier;
// the next request is taken only after the output step, which waits for a free result register.
// Muted object (near_scale zero): the request skips from the wait step straight to the output step.
// Reset (synchronous, active high) restores register defaults, clears filter state, pointer
// and delay-line valid bits at once; no clearing pass.
module binaural_object_renderer
   import bor_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type        cfg_ff;
   logic           rsp_valid_ff;
   logic           csr_wr;
   reg_idx_type    csr_idx;
   seq_status_type status;
   ctl_type        ctl;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = reg_idx_type'(paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_b0      <= '0;
         cfg_ff.tilt_b1      <= '0;
         cfg_ff.tilt_a1      <= '0;
         cfg_ff.air_coeff    <= '0;
         cfg_ff.near_scale   <= 24'd4096;
         cfg_ff.far_scale    <= 24'd4096;
         cfg_ff.itd_delay    <= '0;
         cfg_ff.source_right <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TILT_B0:      cfg_ff.tilt_b0      <= pwdata[14:0];
            REG_TILT_B1:      cfg_ff.tilt_b1      <= pwdata[15:0];
            REG_TILT_A1:      cfg_ff.tilt_a1      <= pwdata[15:0];
            REG_AIR_COEFF:    cfg_ff.air_coeff    <= pwdata[14:0];
            REG_NEAR_SCALE:   cfg_ff.near_scale   <= pwdata[23:0];
            REG_FAR_SCALE:    cfg_ff.far_scale    <= pwdata[23:0];
            REG_ITD_DELAY:    cfg_ff.itd_delay    <= pwdata[ITD_DELAY_W-1:0];
            REG_SOURCE_RIGHT: cfg_ff.source_right <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TILT_B0:      prdata = {{(CSR_DW-15){1'b0}}, cfg_ff.tilt_b0};
         REG_TILT_B1:      prdata = {{(CSR_DW-16){1'b0}}, cfg_ff.tilt_b1};
         REG_TILT_A1:      prdata = {{(CSR_DW-16){1'b0}}, cfg_ff.tilt_a1};
         REG_AIR_COEFF:    prdata = {{(CSR_DW-15){1'b0}}, cfg_ff.air_coeff};
         REG_NEAR_SCALE:   prdata = {{(CSR_DW-24){1'b0}}, cfg_ff.near_scale};
         REG_FAR_SCALE:    prdata = {{(CSR_DW-24){1'b0}}, cfg_ff.far_scale};
         REG_ITD_DELAY:    prdata = {{(CSR_DW-ITD_DELAY_W){1'b0}}, cfg_ff.itd_delay};
         REG_SOURCE_RIGHT: prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.source_right};
      endcase
   end

   assign status.req_valid = req_valid;
   assign status.mute      = (cfg_ff.near_scale == '0);
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   bor_seq u_seq (
      .clock (clock),
      .reset (reset),
      .status(status),
      .ctl   (ctl)
   );

   bor_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .ctl     (ctl),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

   assign req_ready = ctl.req_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.ld_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_top_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_top_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous request still in work");

endmodule

@@ bench/bor_mix_checker.sv @@
// Scoreboard for the binaural object renderer: tracks register writes, predicts each mix
// result with its own fixed-point filter, delay-line and gain model, and compares.
// Depends on bor_pkg for the request/response structs, register indexes and widths.
module bor_mix_checker
   import bor_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output int                errors,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [14:0]              b0_q;
   logic signed [15:0]       b1_q;
   logic signed [15:0]       a1_q;
   logic [14:0]              air_q;
   logic [23:0]              near_q;
   logic [23:0]              far_q;
   logic [ITD_DELAY_W-1:0]   delay_q;
   logic                     right_q;

   longint                   tilt_acc;
   longint                   air_acc;
   logic signed [SMP_W-1:0]  itd_mem [LINE_LEN];
   int                       wr_idx;

   rsp_type                  expected_mix [$];
   rsp_type                  want;

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic longint clip(input longint v, input int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < -hi - 1) begin
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic rsp_type render_sample(input req_type r);
      longint  x;
      longint  y;
      longint  mono;
      longint  delayed;
      longint  near_s;
      longint  far_s;
      longint  lsum;
      longint  rsum;
      int      d;
      int      rd;
      rsp_type o;
      if (near_q == '0) begin
         o.left_out  = r.left_in;
         o.right_out = r.right_in;
         return o;
      end
      x = longint'(r.sample_in);
      y = clip(round_shift(longint'(b0_q) * x, 15) + tilt_acc, ST_W);
      tilt_acc = clip(round_shift(longint'(b1_q) * x - longint'(a1_q) * y, 15), ST_W);
      air_acc = clip(air_acc + round_shift(longint'(air_q) * (y - air_acc), 15), ST_W);
      mono = clip(air_acc, SMP_W);
      itd_mem[wr_idx] = mono[SMP_W-1:0];
      d = (delay_q >= ITD_MAX) ? ITD_MAX - 1 : int'(delay_q);
      rd = (wr_idx + LINE_LEN - d) % LINE_LEN;
      delayed = longint'(itd_mem[rd]);
      wr_idx = (wr_idx + 1) % LINE_LEN;
      near_s = round_shift(mono * longint'(near_q), 12);
      far_s  = round_shift(delayed * longint'(far_q), 12);
      if (right_q) begin
         lsum = clip(longint'(r.left_in) + far_s, SMP_W);
         rsum = clip(longint'(r.right_in) + near_s, SMP_W);
      end else begin
         lsum = clip(longint'(r.left_in) + near_s, SMP_W);
         rsum = clip(longint'(r.right_in) + far_s, SMP_W);
      end
      o.left_out  = lsum[SMP_W-1:0];
      o.right_out = rsum[SMP_W-1:0];
      return o;
   endfunction

   task automatic store_reg(input logic [2:0] idx, input logic [CSR_DW-1:0] v);
      case (reg_idx_type'(idx))
         REG_TILT_B0:      b0_q    = v[14:0];
         REG_TILT_B1:      b1_q    = v[15:0];
         REG_TILT_A1:      a1_q    = v[15:0];
         REG_AIR_COEFF:    air_q   = v[14:0];
         REG_NEAR_SCALE:   near_q  = v[23:0];
         REG_FAR_SCALE:    far_q   = v[23:0];
         REG_ITD_DELAY:    delay_q = v[ITD_DELAY_W-1:0];
         REG_SOURCE_RIGHT: right_q = v[0];
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         b0_q     = '0;
         b1_q     = '0;
         a1_q     = '0;
         air_q    = '0;
         near_q   = 24'd4096;
         far_q    = 24'd4096;
         delay_q  = '0;
         right_q  = 1'b1;
         tilt_acc = 0;
         air_acc  = 0;
         wr_idx   = 0;
         foreach (itd_mem[i]) begin
            itd_mem[i] = '0;
         end
         expected_mix.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            store_reg(paddr[CSR_AW-1:2], pwdata);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_mix.size() == 0) begin
               report_mismatch($sformatf("response %0d/%0d with no request outstanding",
                                         rsp_data.left_out, rsp_data.right_out));
            end else begin
               want = expected_mix.pop_front();
               if (rsp_data.left_out !== want.left_out) begin
                  report_mismatch($sformatf("left_out expected %0d got %0d",
                                            want.left_out, rsp_data.left_out));
               end
               if (rsp_data.right_out !== want.right_out) begin
                  report_mismatch($sformatf("right_out expected %0d got %0d",
                                            want.right_out, rsp_data.right_out));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_mix.push_back(render_sample(req_data));
         end
      end
      pending <= expected_mix.size();
   end

endmodule

@@ bench/tb_binaural_object_renderer.sv @@
// Top of the binaural object renderer bench: clock, reset, request and register stimulus,
// response pacing, watchdog and verdict. Depends on bor_pkg, the renderer and bor_mix_checker.
module tb_binaural_object_renderer
   import bor_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 8;
   localparam int HOLD_LEN        = 300;
   localparam int IDLE_LIMIT      = 2000;
   localparam int TAIL_CYCLES     = 16;
   localparam int ITEMS_PER_PHASE = 195;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = '0;
   logic [CSR_DW-1:0] pwdata    = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int errors;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_starts   = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int n_sent        = 0;
   int n_settings    = 0;
   int n_muted       = 0;
   logic [15:0] walk_val = '0;

   binaural_object_renderer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   bor_mix_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .pready    (pready),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .errors    (errors),
      .pending   (pending)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_starts) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_LEN;
         hold_taken <= hold_starts;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("binaural_object_renderer test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [15:0] rand_word();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = 16'h7FFF;
         1: v = 16'h8000;
         2, 3: begin
            v = 16'($urandom_range(0, 511));
            if ($urandom_range(1)) begin
               v = -v;
            end
         end
         default: v = 16'($urandom());
      endcase
      return v;
   endfunction

   task automatic send_req(input logic [15:0] s, input logic [15:0] l, input logic [15:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample_in: s, left_in: l, right_in: r};
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      n_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input reg_idx_type idx, input logic [CSR_DW-1:0] v, input int w);
      logic [CSR_DW-1:0] mask;
      mask = (CSR_DW'(1) << w) - 1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= ($urandom() & ~mask) | (v & mask);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_settings(input logic [14:0] b0, input logic [15:0] b1,
                                   input logic [15:0] a1, input logic [14:0] air,
                                   input logic [23:0] near, input logic [23:0] far,
                                   input logic [5:0] dly, input logic right);
      write_csr(REG_TILT_B0, b0, 15);
      write_csr(REG_TILT_B1, b1, 16);
      write_csr(REG_TILT_A1, a1, 16);
      write_csr(REG_AIR_COEFF, air, 15);
      write_csr(REG_NEAR_SCALE, near, 24);
      write_csr(REG_FAR_SCALE, far, 24);
      write_csr(REG_ITD_DELAY, dly, ITD_DELAY_W);
      write_csr(REG_SOURCE_RIGHT, right, 1);
      n_settings++;
      if (near == '0) begin
         n_muted++;
      end
   endtask

   task automatic random_settings();
      logic [14:0] b0;
      logic [14:0] air;
      logic [23:0] near;
      logic [23:0] far;
      logic [5:0]  dly;
      case ($urandom_range(4))
         0: b0 = '0;
         1: b0 = 15'h7FFF;
         default: b0 = 15'($urandom());
      endcase
      case ($urandom_range(4))
         0: air = '0;
         1: air = 15'h7FFF;
         default: air = 15'($urandom());
      endcase
      case ($urandom_range(7))
         0: near = '0;
         1: near = 24'hFFFFFF;
         2: near = 24'($urandom());
         default: near = 24'($urandom_range(1, 8192));
      endcase
      case ($urandom_range(6))
         0: far = '0;
         1: far = 24'hFFFFFF;
         2: far = 24'($urandom());
         default: far = 24'($urandom_range(0, 8192));
      endcase
      case ($urandom_range(4))
         0: dly = '0;
         1: dly = 6'd63;
         default: dly = 6'($urandom());
      endcase
      program_settings(b0, rand_word(), rand_word(), air, near, far, dly, 1'($urandom()));
   endtask

   task automatic run_phase(input int snd_pct, input int rcv_pct, input bit long_hold);
      int done;
      int n;
      bit walk;
      done = 0;
      send_idle_pct = snd_pct;
      recv_idle_pct <= rcv_pct;
      while (done < ITEMS_PER_PHASE) begin
         wait_drained();
         random_settings();
         if (long_hold && done == 0) begin
            hold_starts <= hold_starts + 1;
         end
         n = $urandom_range(15, 50);
         walk = $urandom_range(3) != 0;
         repeat (n) begin
            if (walk) begin
               walk_val = walk_val + 16'($signed($urandom_range(0, 4096)) - 2048);
               send_req(walk_val, rand_word(), rand_word());
            end else begin
               send_req(rand_word(), rand_word(), rand_word());
            end
            done++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) begin
         @(posedge clock);
      end
      reset <= 1'b0;
      @(posedge clock);

      // defaults: zero tilt gain, pass-through mix
      send_req(16'h7FFF, 16'h7FFF, 16'h8000);
      send_req(16'h8000, 16'h8000, 16'h7FFF);
      send_req(16'h0000, 16'hFFFF, 16'h0001);

      // saturate the filters, longest delay, left ear near
      wait_drained();
      program_settings(15'h7FFF, 16'h7FFF, 16'h8000, 15'h7FFF,
                       24'hFFFFFF, 24'hFFFFFF, 6'd63, 1'b0);
      send_req(16'h7FFF, 16'h0000, 16'h0000);
      send_req(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_req(16'h7FFF, 16'h8000, 16'h8000);
      send_req(16'h8000, 16'h7FFF, 16'h8000);
      send_req(16'h8000, 16'h8000, 16'h7FFF);
      send_req(16'h8000, 16'h0000, 16'h0000);
      send_req(16'h0000, 16'h1234, 16'hEDCB);
      send_req(16'h0001, 16'h0000, 16'h0000);

      // muted object
      wait_drained();
      program_settings(15'd16384, 16'hE000, 16'h4000, 15'd8192, 24'd0, 24'd4096, 6'd5, 1'b1);
      send_req(16'h7FFF, 16'h7FFF, 16'h8000);
      send_req(16'h8000, 16'h1111, 16'h2222);
      send_req(16'h5555, 16'hAAAA, 16'h5555);

      wait_drained();
      program_settings(15'h7FFF, 16'h8000, 16'h7FFF, 15'd0, 24'd1, 24'd0, 6'd0, 1'b1);
      send_req(16'h7FFF, 16'h0000, 16'h7FFF);
      send_req(16'h8000, 16'h8000, 16'h0000);
      send_req(16'h4000, 16'h0100, 16'hFF00);

      // zero delay, right ear near
      wait_drained();
      program_settings(15'd20000, 16'h1000, 16'hC000, 15'd16000, 24'd4096, 24'd4096, 6'd0, 1'b1);
      send_req(16'h7FFF, 16'h0000, 16'h0000);
      send_req(16'h8000, 16'h7000, 16'h9000);
      send_req(16'h2000, 16'h7FFF, 16'h7FFF);
      send_req(16'hE000, 16'h8000, 16'h8000);

      run_phase(37, 74, 1'b0);
      run_phase(74, 37, 1'b0);
      run_phase(0, 0, 1'b1);

      wait_drained();
      repeat (TAIL_CYCLES) begin
         @(posedge clock);
      end
      $display("Rendered %0d requests, %0d register settings (%0d muted), three pacings",
               n_sent, n_settings, n_muted);
      $display("incl. filter saturation, zero and longest delay, both near ears, long output stall");
      if (errors == 0 && pending == 0) begin
         $display("binaural_object_renderer test passed");
      end else begin
         $display("binaural_object_renderer test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/bor_pkg.sv
src/bor_ram.sv
src/bor_seq.sv
src/bor_dp.sv
src/binaural_object_renderer.sv
bench/bor_mix_checker.sv
bench/tb_binaural_object_renderer.sv
